[src/ydbd_pkg.sv]
// Shared constants, types and the exp lookup table of the YOLO box decoder.
// Used by the configuration block, the arithmetic units and the top level.
package ydbd_pkg;

	localparam int ANCHORS_PER_CELL = 3;
	localparam int MAX_CLASSES      = 256;
	localparam int RELATIVE_OUTPUT  = 0;
	localparam int EXP_TABLE_DEPTH  = 256;

	localparam int EXP_AW  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int EXP_W   = 36;
	localparam int MUL_AW  = 36;
	localparam int MUL_BW  = 16;
	localparam int MUL_PW  = MUL_AW + MUL_BW;
	localparam int DIV_NW  = 48;
	localparam int DIV_DW  = 16;
	localparam int CLS_W   = 8;
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	// register indexes (byte address is 8 * index)
	localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_GRID_WIDTH      = 3'd1;
	localparam logic [2:0] REG_GRID_HEIGHT     = 3'd2;
	localparam logic [2:0] REG_NETWORK_WIDTH   = 3'd3;
	localparam logic [2:0] REG_NETWORK_HEIGHT  = 3'd4;
	localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd5;
	localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd6;
	localparam logic [2:0] REG_ANCHOR_TABLE    = 3'd7;

	// table step exp(16/depth) in Q8.24 from an eleven-term Taylor sum, truncating each term
	localparam logic [63:0] EXP_H   = (64'd16 << 24) / EXP_TABLE_DEPTH;
	localparam logic [63:0] EXP_T0  = 64'd1 << 24;
	localparam logic [63:0] EXP_T1  = ((EXP_T0 * EXP_H) >> 24) / 64'd1;
	localparam logic [63:0] EXP_T2  = ((EXP_T1 * EXP_H) >> 24) / 64'd2;
	localparam logic [63:0] EXP_T3  = ((EXP_T2 * EXP_H) >> 24) / 64'd3;
	localparam logic [63:0] EXP_T4  = ((EXP_T3 * EXP_H) >> 24) / 64'd4;
	localparam logic [63:0] EXP_T5  = ((EXP_T4 * EXP_H) >> 24) / 64'd5;
	localparam logic [63:0] EXP_T6  = ((EXP_T5 * EXP_H) >> 24) / 64'd6;
	localparam logic [63:0] EXP_T7  = ((EXP_T6 * EXP_H) >> 24) / 64'd7;
	localparam logic [63:0] EXP_T8  = ((EXP_T7 * EXP_H) >> 24) / 64'd8;
	localparam logic [63:0] EXP_T9  = ((EXP_T8 * EXP_H) >> 24) / 64'd9;
	localparam logic [63:0] EXP_T10 = ((EXP_T9 * EXP_H) >> 24) / 64'd10;
	localparam logic [63:0] EXP_S   = EXP_T0 + EXP_T1 + EXP_T2 + EXP_T3 + EXP_T4 + EXP_T5
		+ EXP_T6 + EXP_T7 + EXP_T8 + EXP_T9 + EXP_T10;

	// sizes are already forced to at least one
	typedef struct packed {
		logic [15:0] thr;
		logic [7:0]  gw;
		logic [7:0]  gh;
		logic [11:0] nw;
		logic [11:0] nh;
		logic [15:0] iw;
		logic [15:0] ih;
		logic [59:0] anchors;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [MUL_AW-1:0] a;
		logic [MUL_BW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];

	// exp points over [-8, 8] in Q12.24, each one step times the previous
	function automatic exp_tab_t exp_build();
		exp_tab_t    t;
		logic [63:0] v;
		v    = 64'd5628;
		t[0] = v[EXP_W-1:0];
		for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
			v    = (v * EXP_S + (64'd1 << 23)) >> 24;
			t[i] = v[EXP_W-1:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TAB = exp_build();

endpackage

[src/ydbd_in_if.sv]
// Input channel of the box decoder: valid/ready plus one box or class item.
// No dependencies.
interface ydbd_in_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [7:0]         cell_column;
	logic [7:0]         cell_row;
	logic [1:0]         anchor_slot;
	logic [15:0]        offset_x;
	logic [15:0]        offset_y;
	logic signed [15:0] log_width;
	logic signed [15:0] log_height;
	logic [15:0]        value;
	logic               class_last;

	modport source(output valid, req_type, cell_column, cell_row, anchor_slot, offset_x,
		offset_y, log_width, log_height, value, class_last, input ready);
	modport sink(input valid, req_type, cell_column, cell_row, anchor_slot, offset_x,
		offset_y, log_width, log_height, value, class_last, output ready);
endinterface

[src/ydbd_out_if.sv]
// Output channel of the box decoder: valid/ready plus one box or class result.
// No dependencies.
interface ydbd_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [15:0]        detection_index;
	logic signed [31:0] box_center_x;
	logic signed [31:0] box_center_y;
	logic signed [31:0] box_width;
	logic signed [31:0] box_height;
	logic [15:0]        score;
	logic [7:0]         class_number;
	logic               last;

	modport source(output valid, result_kind, detection_index, box_center_x, box_center_y,
		box_width, box_height, score, class_number, last, input ready);
	modport sink(input valid, result_kind, detection_index, box_center_x, box_center_y,
		box_width, box_height, score, class_number, last, output ready);
endinterface

[src/ydbd_cfg.sv]
// APB register file of the box decoder: eight registers at 8-byte spacing.
// Depends on ydbd_pkg.
module ydbd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ydbd_pkg::PADDR_W-1:0]  paddr,
	input  logic [ydbd_pkg::PDATA_W-1:0]  pwdata,
	output logic [ydbd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output ydbd_pkg::cfg_t                cfg
);
	import ydbd_pkg::*;

	logic [15:0] thr_q;
	logic [7:0]  gw_q;
	logic [7:0]  gh_q;
	logic [11:0] nw_q;
	logic [11:0] nh_q;
	logic [15:0] iw_q;
	logic [15:0] ih_q;
	logic [59:0] anc_q;
	logic [2:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:3];
	assign wr     = psel && penable && pwrite;

	// write on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 16'd32768;
			gw_q  <= 8'd13;
			gh_q  <= 8'd13;
			nw_q  <= 12'd416;
			nh_q  <= 12'd416;
			iw_q  <= 16'd416;
			ih_q  <= 16'd416;
			anc_q <= '0;
		end else if (wr) begin
			case (idx)
				REG_SCORE_THRESHOLD: thr_q <= pwdata[15:0];
				REG_GRID_WIDTH:      gw_q  <= pwdata[7:0];
				REG_GRID_HEIGHT:     gh_q  <= pwdata[7:0];
				REG_NETWORK_WIDTH:   nw_q  <= pwdata[11:0];
				REG_NETWORK_HEIGHT:  nh_q  <= pwdata[11:0];
				REG_IMAGE_WIDTH:     iw_q  <= pwdata[15:0];
				REG_IMAGE_HEIGHT:    ih_q  <= pwdata[15:0];
				REG_ANCHOR_TABLE:    anc_q <= pwdata[59:0];
				default: ;
			endcase
		end
	end

	// read back the raw register
	always_comb begin
		case (idx)
			REG_SCORE_THRESHOLD: prdata = {48'd0, thr_q};
			REG_GRID_WIDTH:      prdata = {56'd0, gw_q};
			REG_GRID_HEIGHT:     prdata = {56'd0, gh_q};
			REG_NETWORK_WIDTH:   prdata = {52'd0, nw_q};
			REG_NETWORK_HEIGHT:  prdata = {52'd0, nh_q};
			REG_IMAGE_WIDTH:     prdata = {48'd0, iw_q};
			REG_IMAGE_HEIGHT:    prdata = {48'd0, ih_q};
			REG_ANCHOR_TABLE:    prdata = {4'd0, anc_q};
			default:             prdata = '0;
		endcase
	end

	// treat a zero size as one
	always_comb begin
		cfg.thr     = thr_q;
		cfg.gw      = (gw_q == '0) ? 8'd1 : gw_q;
		cfg.gh      = (gh_q == '0) ? 8'd1 : gh_q;
		cfg.nw      = (nw_q == '0) ? 12'd1 : nw_q;
		cfg.nh      = (nh_q == '0) ? 12'd1 : nh_q;
		cfg.iw      = (iw_q == '0) ? 16'd1 : iw_q;
		cfg.ih      = (ih_q == '0) ? 16'd1 : ih_q;
		cfg.anchors = anc_q;
	end
endmodule

[src/ydbd_mul.sv]
// Shared unsigned 36x16 multiplier with a registered product.
// Depends on ydbd_pkg.
module ydbd_mul (
	input  logic                          clk,
	input  ydbd_pkg::mul_req_t            req,
	output logic [ydbd_pkg::MUL_PW-1:0]   prod
);
	import ydbd_pkg::*;

	logic [MUL_PW-1:0] prod_q;

	// hold the product until the next issue
	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= MUL_PW'(req.a) * MUL_PW'(req.b);
		end
	end

	assign prod = prod_q;
endmodule

[src/ydbd_div.sv]
// Shared radix-2 restoring divider, unsigned 48 by 16 bits, one bit a cycle.
// Depends on ydbd_pkg.
module ydbd_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ydbd_pkg::div_req_t req,
	output ydbd_pkg::div_rsp_t rsp
);
	import ydbd_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   shr;
	logic              ge;
	logic [DIV_DW:0]   nrem;

	// one trial subtract per cycle
	assign shr  = {rem_q, quo_q[DIV_NW-1]};
	assign ge   = shr >= {1'b0, den_q};
	assign nrem = ge ? shr - {1'b0, den_q} : shr;

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// shift quotient bits in
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= nrem[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

[src/yolo_detection_box_decoder_core.sv]
// Decodes one YOLO output layer item by item. A box item whose objectness is above the
// threshold runs through a sequencer over one shared 36x16 multiplier, the exp table and
// one shared radix-2 divider; its time is dominated by nine 48-bit divisions. A box that
// fails is dropped in the idle state, a class item runs a multiply and a finish step, and
// the output step moves a result into the output register. The block takes one item at a time;
// the next item is accepted while a finished result still waits in the output register.
module yolo_detection_box_decoder_core (
	input  logic                          clk,
	input  logic                          arst_n,
	ydbd_in_if.sink                       det_in,
	ydbd_out_if.source                    det_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ydbd_pkg::PADDR_W-1:0]  paddr,
	input  logic [ydbd_pkg::PDATA_W-1:0]  pwdata,
	output logic [ydbd_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ydbd_pkg::*;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_QMUL = 5'd1;
	localparam logic [4:0] ST_QFIN = 5'd2;
	localparam logic [4:0] ST_ELO  = 5'd3;
	localparam logic [4:0] ST_EHI  = 5'd4;
	localparam logic [4:0] ST_EMUL = 5'd5;
	localparam logic [4:0] ST_AMUL = 5'd6;
	localparam logic [4:0] ST_SDIV = 5'd7;
	localparam logic [4:0] ST_GDIV = 5'd8;
	localparam logic [4:0] ST_LM1  = 5'd9;
	localparam logic [4:0] ST_LM2  = 5'd10;
	localparam logic [4:0] ST_LCMP = 5'd11;
	localparam logic [4:0] ST_LDIV = 5'd12;
	localparam logic [4:0] ST_PMUL = 5'd13;
	localparam logic [4:0] ST_PDIV = 5'd14;
	localparam logic [4:0] ST_ZMUL = 5'd15;
	localparam logic [4:0] ST_ZDIV = 5'd16;
	localparam logic [4:0] ST_SMUL = 5'd17;
	localparam logic [4:0] ST_SFIN = 5'd18;
	localparam logic [4:0] ST_OUT  = 5'd19;

	localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
	localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > SAT_MAX) return 32'sh7FFFFFFF;
		if (v < SAT_MIN) return 32'sh80000000;
		return v[31:0];
	endfunction

	cfg_t              cfg;
	mul_req_t          mul_req;
	logic [MUL_PW-1:0] mul_q;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// control state
	logic [4:0]        state_q;
	logic              dim_q;
	logic [1:0]        k_q;
	logic              div_wait_q;
	logic [15:0]       held_q;
	logic              passed_q;
	logic [15:0]       det_cnt_q;
	logic [CLS_W-1:0]  cls_cnt_q;
	logic              out_valid_q;

	// latched item
	logic              kind_q;
	logic [7:0]        col_q;
	logic [7:0]        row_q;
	logic [1:0]        slot_q;
	logic [15:0]       ox_q;
	logic [15:0]       oy_q;
	logic [15:0]       lw_q;
	logic [15:0]       lh_q;
	logic [15:0]       val_q;
	logic              clast_q;

	// working registers
	logic [EXP_W-1:0]  lo_q;
	logic [EXP_W-1:0]  hi_q;
	logic [23:0]       pos_q [2];
	logic [30:0]       sz_q [2];
	logic [27:0]       p1_q;
	logic              lt_q;
	logic [11:0]       neww_q;
	logic [11:0]       newh_q;
	logic signed [31:0] res_q [4];
	logic [15:0]       prob_q;
	logic [CLS_W-1:0]  pcls_q;
	logic              plast_q;

	// output register
	logic              o_kind_q;
	logic [15:0]       o_idx_q;
	logic signed [31:0] o_cx_q;
	logic signed [31:0] o_cy_q;
	logic signed [31:0] o_w_q;
	logic signed [31:0] o_h_q;
	logic [15:0]       o_score_q;
	logic [7:0]        o_cls_q;
	logic              o_last_q;

	logic              in_acc;
	logic              div_fire;
	logic              out_load;
	logic [15:0]       lg;
	logic [15:0]       lg_u;
	logic [16+EXP_AW-1:0] pexp;
	logic [EXP_AW-1:0] eidx;
	logic [EXP_AW-1:0] taddr;
	logic [EXP_W-1:0]  tab_rd;
	logic [15:0]       efr;
	logic [1:0]        slot_eff;
	logic [9:0]        aw;
	logic [9:0]        ah;
	logic [11:0]       nd;
	logic [7:0]        gd;
	logic [11:0]       newd;
	logic signed [37:0] cnum;
	logic              cneg;
	logic [36:0]       cmag;
	logic signed [49:0] qsgn;
	logic [39:0]       szv;
	logic [11:0]       lq;
	logic signed [31:0] rk;
	logic [31:0]       rk_mag;
	logic signed [49:0] ssgn;
	logic [31:0]       prnd;
	logic [15:0]       prob;
	logic              clast_eff;
	logic              relative;

	ydbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ydbd_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_q)
	);

	ydbd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign relative     = (RELATIVE_OUTPUT != 0);
	assign det_in.ready = (state_q == ST_IDLE);
	assign in_acc       = det_in.valid && det_in.ready;
	assign div_fire     = div_wait_q && div_rsp.done;
	assign out_load     = (state_q == ST_OUT) && (!out_valid_q || det_out.ready);

	// exp table address and interpolation fraction
	assign lg    = dim_q ? lh_q : lw_q;
	assign lg_u  = lg ^ 16'h8000;
	assign pexp  = (16 + EXP_AW)'(lg_u) * (16 + EXP_AW)'(EXP_TABLE_DEPTH);
	assign eidx  = pexp[16+EXP_AW-1:16];
	assign efr   = pexp[15:0];
	assign taddr = (state_q == ST_EHI) ? eidx + 1'b1 : eidx;
	assign tab_rd = EXP_TAB[taddr];

	// per-axis operand selection
	assign slot_eff = (slot_q >= 2'(ANCHORS_PER_CELL)) ? 2'(ANCHORS_PER_CELL - 1) : slot_q;
	assign aw   = cfg.anchors[slot_eff*20 +: 10];
	assign ah   = cfg.anchors[slot_eff*20+10 +: 10];
	assign nd   = dim_q ? cfg.nh : cfg.nw;
	assign gd   = dim_q ? cfg.gh : cfg.gw;
	assign newd = dim_q ? newh_q : neww_q;

	// letterbox centre numerator, signed, split into sign and magnitude
	assign cnum = $signed({2'b00, mul_q[35:0]}) - $signed({11'd0, 12'(nd - newd), 15'd0});
	assign cneg = cnum[37];
	assign cmag = cneg ? 37'(-cnum) : 37'(cnum);
	assign qsgn = cneg ? -$signed({2'b00, div_rsp.quo}) : $signed({2'b00, div_rsp.quo});
	assign szv  = div_rsp.quo[DIV_NW-1:8];
	assign lq   = (div_rsp.quo == '0) ? 12'd1 : div_rsp.quo[11:0];

	// image scaling in sign and magnitude
	assign rk     = res_q[k_q];
	assign rk_mag = rk[31] ? 32'(-rk) : 32'(rk);
	assign ssgn   = rk[31] ? -$signed({2'b00, mul_q[47:0]}) : $signed({2'b00, mul_q[47:0]});

	// class probability with rounding and threshold
	assign prnd      = mul_q[31:0] + 32'h8000;
	assign prob      = (prnd[31:16] <= cfg.thr) ? 16'd0 : prnd[31:16];
	assign clast_eff = clast_q || (cls_cnt_q == CLS_W'(MAX_CLASSES - 1));

	// drive the shared multiplier
	always_comb begin
		mul_req.en = 1'b1;
		mul_req.a  = '0;
		mul_req.b  = '0;
		case (state_q)
			ST_QMUL: begin
				mul_req.a = MUL_AW'(held_q);
				mul_req.b = val_q;
			end
			ST_EMUL: begin
				mul_req.a = hi_q - lo_q;
				mul_req.b = efr;
			end
			ST_AMUL: begin
				mul_req.a = EXP_W'(lo_q + mul_q[MUL_PW-1:16]);
				mul_req.b = MUL_BW'(dim_q ? ah : aw);
			end
			ST_LM1: begin
				mul_req.a = MUL_AW'(cfg.nw);
				mul_req.b = cfg.ih;
			end
			ST_LM2: begin
				mul_req.a = MUL_AW'(cfg.nh);
				mul_req.b = cfg.iw;
			end
			ST_PMUL: begin
				mul_req.a = MUL_AW'(pos_q[dim_q]);
				mul_req.b = MUL_BW'(nd);
			end
			ST_ZMUL: begin
				mul_req.a = MUL_AW'(sz_q[dim_q]);
				mul_req.b = MUL_BW'(nd);
			end
			ST_SMUL: begin
				mul_req.a = MUL_AW'(rk_mag);
				mul_req.b = k_q[0] ? cfg.ih : cfg.iw;
			end
			default: mul_req.en = 1'b0;
		endcase
	end

	// drive the shared divider
	always_comb begin
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			ST_SDIV: begin
				div_req.num = mul_q[DIV_NW-1:0];
				div_req.den = DIV_DW'(nd);
			end
			ST_GDIV: begin
				div_req.num = DIV_NW'(dim_q ? {row_q, oy_q} : {col_q, ox_q});
				div_req.den = DIV_DW'(gd);
			end
			ST_LDIV: begin
				div_req.num = DIV_NW'(lt_q ? p1_q : mul_q[27:0]);
				div_req.den = lt_q ? cfg.iw : cfg.ih;
			end
			ST_PDIV: begin
				div_req.num = DIV_NW'(cmag);
				div_req.den = DIV_DW'(newd);
			end
			ST_ZDIV: begin
				div_req.num = mul_q[DIV_NW-1:0];
				div_req.den = DIV_DW'(newd);
			end
			default: ;
		endcase
		div_req.start = (state_q inside {ST_SDIV, ST_GDIV, ST_LDIV, ST_PDIV, ST_ZDIV})
			&& !div_wait_q;
	end

	// sequencer and item state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dim_q       <= 1'b0;
			k_q         <= '0;
			div_wait_q  <= 1'b0;
			held_q      <= '0;
			passed_q    <= 1'b0;
			det_cnt_q   <= '0;
			cls_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_req.start) begin
				div_wait_q <= 1'b1;
			end else if (div_fire) begin
				div_wait_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (det_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					dim_q <= 1'b0;
					k_q   <= '0;
					if (in_acc) begin
						if (!det_in.req_type) begin
							held_q    <= det_in.value;
							cls_cnt_q <= '0;
							passed_q  <= det_in.value > cfg.thr;
							if (det_in.value > cfg.thr) begin
								state_q <= ST_ELO;
							end
						end else if (passed_q) begin
							state_q <= ST_QMUL;
						end
					end
				end
				ST_QMUL: state_q <= ST_QFIN;
				ST_QFIN: begin
					if (clast_eff) begin
						cls_cnt_q <= '0;
						passed_q  <= 1'b0;
					end else begin
						cls_cnt_q <= cls_cnt_q + 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_ELO:  state_q <= ST_EHI;
				ST_EHI:  state_q <= ST_EMUL;
				ST_EMUL: state_q <= ST_AMUL;
				ST_AMUL: state_q <= ST_SDIV;
				ST_SDIV: begin
					if (div_fire) begin
						dim_q   <= !dim_q;
						state_q <= dim_q ? ST_GDIV : ST_ELO;
					end
				end
				ST_GDIV: begin
					if (div_fire) begin
						dim_q   <= !dim_q;
						state_q <= dim_q ? ST_LM1 : ST_GDIV;
					end
				end
				ST_LM1:  state_q <= ST_LM2;
				ST_LM2:  state_q <= ST_LCMP;
				ST_LCMP: state_q <= ST_LDIV;
				ST_LDIV: begin
					if (div_fire) begin
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: state_q <= ST_PDIV;
				ST_PDIV: begin
					if (div_fire) begin
						dim_q   <= !dim_q;
						state_q <= dim_q ? ST_ZMUL : ST_PMUL;
					end
				end
				ST_ZMUL: state_q <= ST_ZDIV;
				ST_ZDIV: begin
					if (div_fire) begin
						dim_q <= !dim_q;
						if (!dim_q) begin
							state_q <= ST_ZMUL;
						end else begin
							state_q <= relative ? ST_OUT : ST_SMUL;
						end
					end
				end
				ST_SMUL: state_q <= ST_SFIN;
				ST_SFIN: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 2'd3) ? ST_OUT : ST_SMUL;
				end
				ST_OUT: begin
					if (out_load) begin
						if (!kind_q) begin
							det_cnt_q <= det_cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					kind_q  <= det_in.req_type;
					col_q   <= det_in.cell_column;
					row_q   <= det_in.cell_row;
					slot_q  <= det_in.anchor_slot;
					ox_q    <= det_in.offset_x;
					oy_q    <= det_in.offset_y;
					lw_q    <= det_in.log_width;
					lh_q    <= det_in.log_height;
					val_q   <= det_in.value;
					clast_q <= det_in.class_last;
				end
			end
			ST_QFIN: begin
				prob_q  <= prob;
				pcls_q  <= cls_cnt_q;
				plast_q <= clast_eff;
			end
			ST_ELO: lo_q <= tab_rd;
			ST_EHI: hi_q <= tab_rd;
			ST_SDIV: begin
				if (div_fire) begin
					sz_q[dim_q] <= (szv > 40'h7FFFFFFF) ? 31'h7FFFFFFF : szv[30:0];
				end
			end
			ST_GDIV: begin
				if (div_fire) begin
					pos_q[dim_q] <= div_rsp.quo[23:0];
				end
			end
			ST_LM2:  p1_q <= mul_q[27:0];
			ST_LCMP: lt_q <= p1_q < mul_q[27:0];
			ST_LDIV: begin
				if (div_fire) begin
					if (lt_q) begin
						neww_q <= cfg.nw;
						newh_q <= lq;
					end else begin
						neww_q <= lq;
						newh_q <= cfg.nh;
					end
				end
			end
			ST_PDIV: begin
				if (div_fire) begin
					res_q[dim_q] <= sat32(qsgn);
				end
			end
			ST_ZDIV: begin
				if (div_fire) begin
					res_q[{1'b1, dim_q}] <= sat32($signed({2'b00, div_rsp.quo}));
				end
			end
			ST_SFIN: res_q[k_q] <= sat32(ssgn);
			default: ;
		endcase

		// load the output register
		if (out_load) begin
			o_kind_q <= kind_q;
			if (!kind_q) begin
				o_idx_q   <= det_cnt_q;
				o_cx_q    <= res_q[0];
				o_cy_q    <= res_q[1];
				o_w_q     <= res_q[2];
				o_h_q     <= res_q[3];
				o_score_q <= val_q;
				o_cls_q   <= '0;
				o_last_q  <= 1'b0;
			end else begin
				o_idx_q   <= det_cnt_q - 1'b1;
				o_cx_q    <= '0;
				o_cy_q    <= '0;
				o_w_q     <= '0;
				o_h_q     <= '0;
				o_score_q <= prob_q;
				o_cls_q   <= pcls_q;
				o_last_q  <= plast_q;
			end
		end
	end

	assign det_out.valid           = out_valid_q;
	assign det_out.result_kind     = o_kind_q;
	assign det_out.detection_index = o_idx_q;
	assign det_out.box_center_x    = o_cx_q;
	assign det_out.box_center_y    = o_cy_q;
	assign det_out.box_width       = o_w_q;
	assign det_out.box_height      = o_h_q;
	assign det_out.score           = o_score_q;
	assign det_out.class_number    = o_cls_q;
	assign det_out.last            = o_last_q;

	// divider is only started when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// no class sequence is open without a passing box
	assert property (@(posedge clk) disable iff (!arst_n)
		!passed_q |-> (cls_cnt_q == '0))
		else $error("class counter set without a passing box");

	// a new result enters the output register only from the output step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("output loaded outside the output step");
endmodule

[test/yolo_detection_box_decoder_core_tb.sv]
// Self-checking bench for the YOLO box decoder core: random and directed box and class
// items, APB register phases, predicted results checked in order. Needs ydbd_pkg,
// ydbd_in_if, ydbd_out_if and yolo_detection_box_decoder_core from the RTL.
`timescale 1ns / 100ps

module yolo_detection_box_decoder_core_tb;
	import ydbd_pkg::*;

	localparam logic KIND_BOX   = 1'b0;
	localparam logic KIND_CLASS = 1'b1;
	localparam int   SETTLE_CYCLES = 600;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;

	typedef struct {
		logic        req_type;
		logic [7:0]  cell_column;
		logic [7:0]  cell_row;
		logic [1:0]  anchor_slot;
		logic [15:0] offset_x;
		logic [15:0] offset_y;
		logic [15:0] log_width;
		logic [15:0] log_height;
		logic [15:0] value;
		logic        class_last;
	} det_item_t;

	typedef struct {
		logic        result_kind;
		logic [15:0] detection_index;
		logic [31:0] box_center_x;
		logic [31:0] box_center_y;
		logic [31:0] box_width;
		logic [31:0] box_height;
		logic [15:0] score;
		logic [7:0]  class_number;
		logic        last;
	} det_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ydbd_in_if  in_ch();
	ydbd_out_if out_ch();

	yolo_detection_box_decoder_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.det_in  (in_ch.sink),
		.det_out (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	det_item_t   stim_q[$];
	det_result_t expected_q[$];
	det_item_t   cur_item;
	int          burst_left;
	int          gap_left;
	int          stall_pct;
	int          stall_left;
	bit          failed;
	longint      cycle_count;

	// predictor copy of registers and state
	longint unsigned thr_r, gw_r, gh_r, nw_r, nh_r, iw_r, ih_r, anchors_r;
	longint unsigned held_obj, box_ok, det_count, class_count;
	longint unsigned exp_pts [0:EXP_TABLE_DEPTH];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// build the exp points over [-8, 8] in Q12.24
	function automatic void build_exp_points();
		longint unsigned step, term, ratio;
		step  = (64'd16 << 24) / EXP_TABLE_DEPTH;
		term  = 64'd1 << 24;
		ratio = term;
		for (int k = 1; k <= 10; k++) begin
			term  = ((term * step) >> 24) / k;
			ratio = ratio + term;
		end
		exp_pts[0] = 64'd5628;
		for (int i = 1; i <= EXP_TABLE_DEPTH; i++)
			exp_pts[i] = (exp_pts[i-1] * ratio + (64'd1 << 23)) >> 24;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > SAT_MAX)
			return SAT_MAX;
		if (v < SAT_MIN)
			return SAT_MIN;
		return v;
	endfunction

	function automatic longint unsigned nonzero(longint unsigned v);
		return (v == 0) ? 64'd1 : v;
	endfunction

	// exp of Q4.12 bits, Q12.24 result, linear between table points
	function automatic longint unsigned exp_interp(logic [15:0] bits);
		longint unsigned p, idx, fr, lo, hi;
		p   = longint'(bits ^ 16'h8000) * EXP_TABLE_DEPTH;
		idx = p >> 16;
		fr  = p & 64'hFFFF;
		lo  = exp_pts[idx];
		hi  = exp_pts[idx + 1];
		return lo + (((hi - lo) * fr) >> 16);
	endfunction

	function automatic longint box_size(logic [15:0] bits, longint unsigned anchor,
			longint unsigned net);
		longint unsigned v;
		v = ((exp_interp(bits) * anchor) / net) >> 8;
		return (v > 64'd2147483647) ? SAT_MAX : longint'(v);
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [63:0] v);
		case (idx)
			REG_SCORE_THRESHOLD: thr_r     = v[15:0];
			REG_GRID_WIDTH:      gw_r      = v[7:0];
			REG_GRID_HEIGHT:     gh_r      = v[7:0];
			REG_NETWORK_WIDTH:   nw_r      = v[11:0];
			REG_NETWORK_HEIGHT:  nh_r      = v[11:0];
			REG_IMAGE_WIDTH:     iw_r      = v[15:0];
			REG_IMAGE_HEIGHT:    ih_r      = v[15:0];
			REG_ANCHOR_TABLE:    anchors_r = v[59:0];
			default: ;
		endcase
	endfunction

	// work out the result of one accepted item, updating the state copy
	function automatic void decode_item(det_item_t it, output bit produced,
			output det_result_t r);
		longint unsigned gw, gh, nw, nh, iw, ih, slot, aw, ah, new_w, new_h, prob;
		longint bx, by, bw, bh, cx, cy, cw, ch;
		bit fin;
		produced = 1'b0;
		r = '{default: '0};
		if (it.req_type == KIND_BOX) begin
			gw = nonzero(gw_r); gh = nonzero(gh_r);
			nw = nonzero(nw_r); nh = nonzero(nh_r);
			iw = nonzero(iw_r); ih = nonzero(ih_r);
			held_obj    = it.value;
			class_count = 0;
			box_ok      = (it.value > thr_r);
			if (!box_ok)
				return;
			slot = it.anchor_slot;
			if (slot >= ANCHORS_PER_CELL)
				slot = ANCHORS_PER_CELL - 1;
			aw = (anchors_r >> (20 * slot)) & 64'h3FF;
			ah = (anchors_r >> (20 * slot + 10)) & 64'h3FF;
			bx = longint'(((longint'(it.cell_column) << 16) + it.offset_x) / gw);
			by = longint'(((longint'(it.cell_row) << 16) + it.offset_y) / gh);
			bw = box_size(it.log_width, aw, nw);
			bh = box_size(it.log_height, ah, nh);
			if (nw * ih < nh * iw) begin
				new_w = nw;
				new_h = ih * nw / iw;
			end else begin
				new_h = nh;
				new_w = iw * nh / ih;
			end
			new_w = nonzero(new_w);
			new_h = nonzero(new_h);
			cx = clamp32((bx * longint'(nw) - longint'((nw - new_w) << 15)) / longint'(new_w));
			cy = clamp32((by * longint'(nh) - longint'((nh - new_h) << 15)) / longint'(new_h));
			cw = clamp32(bw * longint'(nw) / longint'(new_w));
			ch = clamp32(bh * longint'(nh) / longint'(new_h));
			if (RELATIVE_OUTPUT == 0) begin
				cx = clamp32(cx * longint'(iw));
				cw = clamp32(cw * longint'(iw));
				cy = clamp32(cy * longint'(ih));
				ch = clamp32(ch * longint'(ih));
			end
			r.result_kind     = KIND_BOX;
			r.detection_index = det_count[15:0];
			r.box_center_x    = cx[31:0];
			r.box_center_y    = cy[31:0];
			r.box_width       = cw[31:0];
			r.box_height      = ch[31:0];
			r.score           = it.value;
			produced  = 1'b1;
			det_count = (det_count + 1) & 64'hFFFF;
		end else begin
			if (!box_ok)
				return;
			prob = (held_obj * it.value + 64'h8000) >> 16;
			if (prob <= thr_r)
				prob = 0;
			fin = it.class_last || (class_count >= MAX_CLASSES - 1);
			r.result_kind     = KIND_CLASS;
			r.detection_index = 16'(det_count - 1);
			r.score           = prob[15:0];
			r.class_number    = class_count[7:0];
			r.last            = fin;
			produced = 1'b1;
			if (fin) begin
				class_count = 0;
				box_ok      = 0;
			end else begin
				class_count = (class_count + 1) & 64'hFF;
			end
		end
	endfunction

	function automatic det_item_t make_box(bit pass);
		det_item_t it;
		it.req_type    = KIND_BOX;
		it.cell_column = 8'($urandom_range(0, 255));
		it.cell_row    = 8'($urandom_range(0, 255));
		it.anchor_slot = 2'($urandom_range(0, 3));
		it.offset_x    = 16'($urandom_range(0, 65535));
		it.offset_y    = 16'($urandom_range(0, 65535));
		it.log_width   = 16'($urandom_range(0, 65535));
		it.log_height  = 16'($urandom_range(0, 65535));
		it.class_last  = 1'($urandom_range(0, 1));
		if (pass && thr_r < 65535)
			it.value = 16'($urandom_range(thr_r + 1, 65535));
		else if (!pass)
			it.value = 16'($urandom_range(0, thr_r));
		else
			it.value = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic det_item_t make_class(bit fin);
		det_item_t it;
		it = make_box(1'b0);
		it.req_type   = KIND_CLASS;
		it.value      = 16'($urandom_range(0, 65535));
		it.class_last = fin;
		return it;
	endfunction

	// queue one random sequence; returns the number of items added
	function automatic int add_sequence();
		int pick, n;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			n = ($urandom_range(0, 59) == 0) ? 258 : $urandom_range(1, 10);
			stim_q.push_back(make_box(1'b1));
			for (int i = 0; i < n; i++)
				stim_q.push_back(make_class((n < 258) && (i == n - 1)));
			return n + 1;
		end else if (pick < 80) begin
			stim_q.push_back(make_box(1'b0));
			stim_q.push_back(make_class($urandom_range(0, 1)));
			return 2;
		end else if (pick < 88) begin
			stim_q.push_back(make_class($urandom_range(0, 1)));
			return 1;
		end
		// box abandoned mid-classes, next box restarts
		n = $urandom_range(1, 4);
		stim_q.push_back(make_box(1'b1));
		for (int i = 0; i < n; i++)
			stim_q.push_back(make_class(1'b0));
		return n + 1;
	endfunction

	task automatic write_register(logic [2:0] idx, logic [63:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 3'b000});
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_register(idx, v);
	endtask

	task automatic write_all(logic [15:0] thr, logic [7:0] gw, logic [7:0] gh,
			logic [11:0] nw, logic [11:0] nh, logic [15:0] iw, logic [15:0] ih,
			logic [59:0] anc);
		write_register(REG_SCORE_THRESHOLD, 64'(thr));
		write_register(REG_GRID_WIDTH, 64'(gw));
		write_register(REG_GRID_HEIGHT, 64'(gh));
		write_register(REG_NETWORK_WIDTH, 64'(nw));
		write_register(REG_NETWORK_HEIGHT, 64'(nh));
		write_register(REG_IMAGE_WIDTH, 64'(iw));
		write_register(REG_IMAGE_HEIGHT, 64'(ih));
		write_register(REG_ANCHOR_TABLE, 64'(anc));
	endtask

	task automatic drain();
		while (stim_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int added;
		added = 0;
		while (added < count)
			added += add_sequence();
	endtask

	function automatic logic [59:0] rand_anchors();
		return {28'($urandom()), 32'($urandom())};
	endfunction

	// stimulus and register phases
	initial begin
		det_item_t it;
		failed    = 1'b0;
		thr_r     = 32768; gw_r = 13; gh_r = 13;
		nw_r      = 416;   nh_r = 416; iw_r = 416; ih_r = 416;
		anchors_r = 0;
		held_obj  = 0; box_ok = 0; det_count = 0; class_count = 0;
		build_exp_points();
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: zero anchors, class with no box first
		stim_q.push_back(make_class(1'b1));
		run_random(40);
		drain();

		// directed: field extremes, slots, threshold edge, restart mid-classes
		write_all(16'd1000, 8'd13, 8'd13, 12'd416, 12'd416, 16'd640, 16'd480,
			rand_anchors());
		it = make_box(1'b1);
		it.cell_column = 8'd0; it.cell_row = 8'd0; it.anchor_slot = 2'd0;
		it.offset_x = 16'h0000; it.offset_y = 16'h0000;
		it.log_width = 16'h8000; it.log_height = 16'h7FFF; it.value = 16'hFFFF;
		stim_q.push_back(it);
		it = make_class(1'b0); it.value = 16'hFFFF; stim_q.push_back(it);
		it = make_class(1'b0); it.value = 16'h0000; stim_q.push_back(it);
		stim_q.push_back(make_class(1'b1));
		it = make_box(1'b1);
		it.cell_column = 8'hFF; it.cell_row = 8'hFF; it.anchor_slot = 2'd3;
		it.offset_x = 16'hFFFF; it.offset_y = 16'hFFFF;
		it.log_width = 16'h7FFF; it.log_height = 16'h8000; it.value = 16'hFFFF;
		stim_q.push_back(it);
		stim_q.push_back(make_class(1'b1));
		it = make_box(1'b0); it.value = 16'd1000; stim_q.push_back(it);
		stim_q.push_back(make_class(1'b1));
		it = make_box(1'b1); it.value = 16'd1001; it.anchor_slot = 2'd1;
		stim_q.push_back(it);
		stim_q.push_back(make_class(1'b0));
		it = make_box(1'b1); it.anchor_slot = 2'd2; stim_q.push_back(it);
		it = make_class(1'b0); it.value = 16'd0; stim_q.push_back(it);
		stim_q.push_back(make_class(1'b1));
		stim_q.push_back(make_class(1'b1));
		run_random(220);
		drain();

		// largest sizes, all anchors max, zero threshold
		write_all(16'd0, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, '1);
		run_random(200);
		drain();

		// zero sizes are treated as one
		write_all(16'($urandom_range(0, 20000)), 8'd0, 8'd0, 12'd0, 12'd0, 16'd0,
			16'd0, rand_anchors());
		run_random(150);
		drain();

		// random settings, both letterbox branches
		for (int ph = 0; ph < 3; ph++) begin
			write_all(16'($urandom_range(0, 40000)), 8'($urandom_range(1, 255)),
				8'($urandom_range(1, 255)), 12'($urandom_range(1, 4095)),
				12'($urandom_range(1, 4095)), 16'($urandom_range(1, 65535)),
				16'($urandom_range(1, 65535)), rand_anchors());
			run_random(170);
			drain();
		end

		// threshold at its top: nothing passes
		write_register(REG_SCORE_THRESHOLD, 64'hFFFF);
		run_random(40);
		drain();

		if (!failed)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// sender: bursts with random gaps, predict on each transfer
	always @(posedge clk or negedge arst_n) begin
		bit produced;
		det_result_t r;
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.req_type    <= KIND_BOX;
			in_ch.cell_column <= '0;
			in_ch.cell_row    <= '0;
			in_ch.anchor_slot <= '0;
			in_ch.offset_x    <= '0;
			in_ch.offset_y    <= '0;
			in_ch.log_width   <= '0;
			in_ch.log_height  <= '0;
			in_ch.value       <= '0;
			in_ch.class_last  <= 1'b0;
			burst_left        = 0;
			gap_left          = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				decode_item(cur_item, produced, r);
				if (produced)
					expected_q.push_back(r);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left    = gap_left - 1;
					in_ch.valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					cur_item = stim_q.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.req_type    <= cur_item.req_type;
					in_ch.cell_column <= cur_item.cell_column;
					in_ch.cell_row    <= cur_item.cell_row;
					in_ch.anchor_slot <= cur_item.anchor_slot;
					in_ch.offset_x    <= cur_item.offset_x;
					in_ch.offset_y    <= cur_item.offset_y;
					in_ch.log_width   <= cur_item.log_width;
					in_ch.log_height  <= cur_item.log_height;
					in_ch.value       <= cur_item.value;
					in_ch.class_last  <= cur_item.class_last;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end else begin
						burst_left = burst_left - 1;
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	// receiver: stall pattern changes every so often; check each transfer
	always @(posedge clk or negedge arst_n) begin
		det_result_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_pct    = 0;
			stall_left   = 0;
		end else begin
			if (stall_left == 0) begin
				stall_left = $urandom_range(50, 400);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 30;
					2: stall_pct = 70;
					default: stall_pct = 95;
				endcase
			end else begin
				stall_left = stall_left - 1;
			end
			out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, kind %0h index %0h", $time,
						out_ch.result_kind, out_ch.detection_index);
					failed = 1'b1;
				end else begin
					e = expected_q.pop_front();
					check_field("result_kind", 32'(e.result_kind), 32'(out_ch.result_kind));
					check_field("detection_index", 32'(e.detection_index),
						32'(out_ch.detection_index));
					check_field("box_center_x", e.box_center_x, out_ch.box_center_x);
					check_field("box_center_y", e.box_center_y, out_ch.box_center_y);
					check_field("box_width", e.box_width, out_ch.box_width);
					check_field("box_height", e.box_height, out_ch.box_height);
					check_field("score", 32'(e.score), 32'(out_ch.score));
					check_field("class_number", 32'(e.class_number), 32'(out_ch.class_number));
					check_field("last", 32'(e.last), 32'(out_ch.last));
				end
			end
		end
	end

	// stop a hung run
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("%0t: timeout, %0d results still expected", $time, expected_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

[sim.f]
src/ydbd_pkg.sv
src/ydbd_in_if.sv
src/ydbd_out_if.sv
src/ydbd_cfg.sv
src/ydbd_mul.sv
src/ydbd_div.sv
src/yolo_detection_box_decoder_core.sv
test/yolo_detection_box_decoder_core_tb.sv
